// ===== hdl/scmm_pkg.sv =====
// Shared types and constants for the sparse COO matrix multiplier.
// No dependencies; used by the front, back and top-level modules.
package scmm_pkg;

    localparam int MAX_ENTRIES    = 64;
    localparam int RESULT_ENTRIES = 64;
    localparam int IDX_BITS       = 8;
    localparam int VAL_BITS       = 16;
    localparam int SUM_BITS       = 38;
    localparam int TAB_AW         = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS       = $clog2(MAX_ENTRIES + 1);
    localparam int RES_AW         = (RESULT_ENTRIES > 1) ? $clog2(RESULT_ENTRIES) : 1;
    localparam int RES_CNT_BITS   = $clog2(RESULT_ENTRIES + 1);
    localparam int QUEUE_DEPTH    = 4;
    localparam int Q_AW           = $clog2(QUEUE_DEPTH);

    // one classified word passed from the front to the back
    typedef struct packed {
        logic                       is_b;
        logic [IDX_BITS-1:0]        row;
        logic [IDX_BITS-1:0]        col;
        logic signed [VAL_BITS-1:0] value;
        logic                       last;
        logic                       store;
        logic                       dropped;
    } t_word;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

endpackage

// ===== hdl/scmm_front.sv =====
// Front part: accepts load words, tracks table fill, flags dropped loads and
// queues classified words for the back part. Depends on scmm_pkg.
module scmm_front
    import scmm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_which_matrix,
    input  logic [IDX_BITS-1:0]        i_row,
    input  logic [IDX_BITS-1:0]        i_col,
    input  logic signed [VAL_BITS-1:0] i_value,
    input  logic                       i_last,
    input  logic                       i_job_end,
    output logic                       o_busy,
    output logic                       o_q_valid,
    output t_word                      o_q_word,
    input  logic                       i_q_pop
);

    t_word                r_q [QUEUE_DEPTH];
    logic [Q_AW-1:0]      r_wr, r_rd;
    logic [Q_AW:0]        r_fill;
    logic [CNT_BITS-1:0]  r_a_cnt, r_b_cnt;
    logic                 r_job;
    logic                 push;
    logic                 full_sel;
    t_word                w;

    // hold off new words while a job runs or the queue is full
    assign o_busy    = r_job || (r_fill == (Q_AW+1)'(QUEUE_DEPTH));
    assign push      = i_start && !o_busy;
    assign o_q_valid = (r_fill != '0);
    assign o_q_word  = r_q[r_rd];
    assign full_sel  = i_which_matrix ? (r_b_cnt == CNT_BITS'(MAX_ENTRIES))
                                      : (r_a_cnt == CNT_BITS'(MAX_ENTRIES));

    always_comb begin
        w         = '0;
        w.is_b    = i_which_matrix;
        w.row     = i_row;
        w.col     = i_col;
        w.value   = i_value;
        w.last    = i_last;
        w.store   = !full_sel;
        w.dropped = full_sel;
    end

    // store queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= w;
        end
    end

    // advance pointers and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_fill  <= '0;
            r_a_cnt <= '0;
            r_b_cnt <= '0;
            r_job   <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_fill <= r_fill + (Q_AW+1)'(push) - (Q_AW+1)'(i_q_pop);
            if (push && i_last) begin
                r_a_cnt <= '0;
                r_b_cnt <= '0;
                r_job   <= 1'b1;
            end else if (push && !full_sel) begin
                if (i_which_matrix) begin
                    r_b_cnt <= r_b_cnt + 1'b1;
                end else begin
                    r_a_cnt <= r_a_cnt + 1'b1;
                end
            end
            // release the block once the final result has left
            if (i_job_end) begin
                r_job <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/scmm_back.sv =====
// Back part: stores loads into A/B tables, pairs entries, accumulates products
// into the result table and emits results. Depends on scmm_pkg.
module scmm_back
    import scmm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  t_word                      i_q_word,
    output logic                       o_q_pop,
    output logic                       o_done,
    output logic                       o_valid,
    output logic [IDX_BITS-1:0]        o_out_row,
    output logic [IDX_BITS-1:0]        o_out_col,
    output logic signed [SUM_BITS-1:0] o_out_sum,
    output logic                       o_entry_valid,
    output logic                       o_out_last,
    output logic                       o_load_overflow,
    output logic                       o_result_overflow
);

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_RDA   = 7'b0000010,
        S_RDB   = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_SRCH  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_EMPTY = 7'b1000000
    } t_state;

    localparam int ENT_BITS = 2 * IDX_BITS + VAL_BITS;
    localparam int RES_BITS = 2 * IDX_BITS + SUM_BITS;

    logic [ENT_BITS-1:0] a_mem [MAX_ENTRIES];
    logic [ENT_BITS-1:0] b_mem [MAX_ENTRIES];
    logic [RES_BITS-1:0] r_mem [RESULT_ENTRIES];

    t_state                    r_state, n_state;
    logic [CNT_BITS-1:0]       r_a_cnt, r_b_cnt, r_i, r_j;
    logic [RES_CNT_BITS-1:0]   r_rcnt, r_k;
    logic                      r_ldrop, r_rdrop;
    logic [ENT_BITS-1:0]       r_a, r_b;
    logic [RES_BITS-1:0]       r_rd;
    logic signed [2*VAL_BITS-1:0] r_prod;
    logic [IDX_BITS-1:0]       r_pr, r_pc;
    logic                      r_rd_ok;
    logic signed [SUM_BITS:0]  sum_w;
    logic signed [SUM_BITS-1:0] sum_sat;
    logic                      hit;
    logic                      pair_match;
    logic                      r_fr;
    logic                      r_emit_q, r_last_q, r_ldrop_q, r_rdrop_q;

    assign o_q_pop = (r_state == S_LOAD) && i_q_valid;
    assign o_done  = (r_state == S_LOAD);
    assign hit     = r_rd_ok && (r_rd[RES_BITS-1 -: 2*IDX_BITS] == {r_pr, r_pc});
    assign sum_w   = (SUM_BITS+1)'($signed(r_rd[SUM_BITS-1:0])) + (SUM_BITS+1)'(r_prod);
    assign sum_sat = (sum_w > (SUM_BITS+1)'(SUM_MAX)) ? SUM_MAX :
                     (sum_w < (SUM_BITS+1)'(SUM_MIN)) ? SUM_MIN : sum_w[SUM_BITS-1:0];
    // A column meets B row
    assign pair_match = (r_a[VAL_BITS +: IDX_BITS] == r_b[ENT_BITS-1 -: IDX_BITS]);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (o_q_pop && i_q_word.last) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                if (r_i == r_a_cnt || r_b_cnt == '0) begin
                    n_state = (r_rcnt == '0) ? S_EMPTY : S_EMIT;
                end else begin
                    n_state = S_RDB;
                end
            end
            S_RDB: n_state = S_MUL;
            S_MUL: begin
                if (pair_match) begin
                    n_state = S_SRCH;
                end else begin
                    n_state = (r_j == r_b_cnt) ? S_RDA : S_RDB;
                end
            end
            S_SRCH: begin
                if (r_fr && (hit || r_k == r_rcnt)) begin
                    n_state = (r_j == r_b_cnt) ? S_RDA : S_RDB;
                end
            end
            S_EMIT: begin
                if (r_k + 1'b1 == r_rcnt) begin
                    n_state = S_LOAD;
                end
            end
            S_EMPTY: n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    // memories: table writes and registered reads
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_word.store) begin
            if (i_q_word.is_b) begin
                b_mem[r_b_cnt[TAB_AW-1:0]] <= {i_q_word.row, i_q_word.col, i_q_word.value};
            end else begin
                a_mem[r_a_cnt[TAB_AW-1:0]] <= {i_q_word.row, i_q_word.col, i_q_word.value};
            end
        end
        r_a <= a_mem[r_i[TAB_AW-1:0]];
        r_b <= b_mem[r_j[TAB_AW-1:0]];
        r_rd <= r_mem[r_k[RES_AW-1:0]];
        if (r_state == S_SRCH && r_rd_ok && hit) begin
            r_mem[RES_AW'(r_k - 1'b1)] <= {r_pr, r_pc, sum_sat};
        end else if (r_state == S_SRCH && !hit && r_k == r_rcnt
                     && r_rcnt != RES_CNT_BITS'(RESULT_ENTRIES) && r_fr) begin
            r_mem[r_rcnt[RES_AW-1:0]] <= {r_pr, r_pc,
                                         SUM_BITS'(r_prod)};
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_a_cnt <= '0;
            r_b_cnt <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_rcnt  <= '0;
            r_ldrop <= 1'b0;
            r_rdrop <= 1'b0;
            r_rd_ok <= 1'b0;
            r_fr    <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_LOAD: begin
                    r_i <= '0;
                    r_j <= '0;
                    r_k <= '0;
                    if (o_q_pop) begin
                        if (i_q_word.store) begin
                            if (i_q_word.is_b) begin
                                r_b_cnt <= r_b_cnt + 1'b1;
                            end else begin
                                r_a_cnt <= r_a_cnt + 1'b1;
                            end
                        end
                        if (i_q_word.dropped) begin
                            r_ldrop <= 1'b1;
                        end
                    end
                end
                S_RDA: begin
                    r_j <= '0;
                    r_k <= '0;
                end
                S_RDB: begin
                    r_j <= r_j + 1'b1;
                end
                S_MUL: begin
                    r_rd_ok <= 1'b0;
                    r_fr    <= 1'b0;
                    r_k     <= '0;
                    // after a pair whose column and row differ, move to the next A entry once B is exhausted
                    if (!pair_match && r_j == r_b_cnt) begin
                        r_i <= r_i + 1'b1;
                        r_j <= '0;
                    end
                end
                S_SRCH: begin
                    r_fr <= 1'b1;
                    if (r_fr && (hit || r_k == r_rcnt)) begin
                        if (!hit) begin
                            if (r_rcnt == RES_CNT_BITS'(RESULT_ENTRIES)) begin
                                r_rdrop <= 1'b1;
                            end else begin
                                r_rcnt <= r_rcnt + 1'b1;
                            end
                        end
                        r_k <= '0;
                        r_rd_ok <= 1'b0;
                        if (r_j == r_b_cnt) begin
                            r_i <= r_i + 1'b1;
                            r_j <= '0;
                        end
                    end else begin
                        r_rd_ok <= (r_k < r_rcnt);
                        if (r_k < r_rcnt) begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    r_k <= r_k + 1'b1;
                    if (n_state == S_LOAD) begin
                        r_a_cnt <= '0;
                        r_b_cnt <= '0;
                        r_rcnt  <= '0;
                        r_ldrop <= 1'b0;
                        r_rdrop <= 1'b0;
                    end
                end
                S_EMPTY: begin
                    r_a_cnt <= '0;
                    r_b_cnt <= '0;
                    r_ldrop <= 1'b0;
                    r_rdrop <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // hold pair product and its result row and column
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= $signed(r_a[VAL_BITS-1:0]) * $signed(r_b[VAL_BITS-1:0]);
            r_pr   <= r_a[ENT_BITS-1 -: IDX_BITS];
            r_pc   <= r_b[VAL_BITS +: IDX_BITS];
        end
    end

    // result strobe and fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == S_EMPTY) || (r_state == S_EMIT);
        end
    end

    always_comb begin
        o_out_row         = '0;
        o_out_col         = '0;
        o_out_sum         = '0;
        o_entry_valid     = 1'b0;
        o_out_last        = 1'b1;
        o_load_overflow   = r_ldrop_q;
        o_result_overflow = r_rdrop_q;
        if (r_emit_q) begin
            o_out_row     = r_rd[RES_BITS-1 -: IDX_BITS];
            o_out_col     = r_rd[SUM_BITS +: IDX_BITS];
            o_out_sum     = r_rd[SUM_BITS-1:0];
            o_entry_valid = 1'b1;
            o_out_last    = r_last_q;
        end
    end

    // capture result flags alongside the registered read
    always_ff @(posedge i_clk) begin
        r_emit_q  <= (r_state == S_EMIT);
        r_last_q  <= (r_k + 1'b1 == r_rcnt);
        r_ldrop_q <= r_ldrop;
        r_rdrop_q <= r_rdrop;
    end

endmodule

// ===== hdl/sparse_coo_matrix_multiply.sv =====
// Top level of the sparse COO matrix multiplier: front load queue plus back
// pairing and accumulation engine. Depends on scmm_pkg, scmm_front, scmm_back.
//
// channel   direction  handshake            fields
// load      in         start / busy         which_matrix row col value last
// result    out        o_valid strobe       out_row out_col out_sum flags
//
// Loads pass through a four-word queue and are taken whenever busy is low.
// After the last word, a job's run time is set by the sequential search of the
// result table for each matching pair; a pair whose column and row differ
// passes only through the B read and multiply states.
// busy stays high from the last word until the final result has left.
// Results last one cycle each; the receiver cannot stall them.
// Reset is synchronous, active low; tables are undefined until written.
module sparse_coo_matrix_multiply
    import scmm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_which_matrix,
    input  logic [IDX_BITS-1:0]        i_row,
    input  logic [IDX_BITS-1:0]        i_col,
    input  logic signed [VAL_BITS-1:0] i_value,
    input  logic                       i_last,
    output logic                       o_valid,
    output logic [IDX_BITS-1:0]        o_out_row,
    output logic [IDX_BITS-1:0]        o_out_col,
    output logic signed [SUM_BITS-1:0] o_out_sum,
    output logic                       o_entry_valid,
    output logic                       o_out_last,
    output logic                       o_load_overflow,
    output logic                       o_result_overflow
);

    logic  q_valid, q_pop, done, front_busy, job_end;
    t_word q_word;

    // the final result of a job frees the front
    assign job_end = o_valid && o_out_last;

    scmm_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_which_matrix, .i_row, .i_col,
        .i_value, .i_last, .i_job_end(job_end), .o_busy(front_busy),
        .o_q_valid(q_valid), .o_q_word(q_word), .i_q_pop(q_pop)
    );

    scmm_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_word(q_word), .o_q_pop(q_pop),
        .o_done(done), .o_valid, .o_out_row, .o_out_col, .o_out_sum,
        .o_entry_valid, .o_out_last, .o_load_overflow, .o_result_overflow
    );

    assign busy = front_busy;

    // an empty result is always the last of its job
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_entry_valid |-> o_out_last)
        else $error("empty result not marked last");

    // no result while the back part waits for loads
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done && $past(done) && $past(done, 2) |-> !o_valid)
        else $error("result while idle");

    // busy is still high while the final result is shown
    a_last_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_last |-> busy)
        else $error("final result without busy");

endmodule
